[rtl/core/bvs_pkg.sv]
// Shared types and constants for the bounded vector store.
package bvs_pkg;

    localparam int BVS_DEPTH_DEF = 16;
    localparam int BVS_DATA_W    = 32;
    localparam int BVS_FUNC_W    = 3;
    localparam int BVS_IDX_W     = 4;
    localparam int BVS_STAT_W    = 2;
    localparam int BVS_COUNT_W   = 5;
    // Cell position width, wide enough for the largest supported depth (1024).
    localparam int BVS_POS_W     = 11;

    typedef enum logic [BVS_FUNC_W-1:0] {
        FN_APPEND  = 3'd0,
        FN_POP     = 3'd1,
        FN_SET     = 3'd2,
        FN_INSERT  = 3'd3,
        FN_REVERSE = 3'd4,
        FN_CLEAR   = 3'd5,
        FN_READ    = 3'd6
    } bvs_func_t;

    typedef enum logic [BVS_STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } bvs_status_t;

    // Command broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_WRITE  = 2'd1,   // cell at pos loads value
        CMD_INSERT = 2'd2,   // cell at pos loads value, cells pos+1..lim take lower neighbor
        CMD_ROTATE = 2'd3    // cells below lim take upper neighbor, cell lim takes cell 0
    } bvs_cmd_kind_t;

    typedef struct packed {
        bvs_cmd_kind_t                 kind;
        logic [BVS_POS_W-1:0]          pos;
        logic [BVS_POS_W-1:0]          lim;
        logic signed [BVS_DATA_W-1:0]  value;
    } bvs_cmd_t;

endpackage

[rtl/core/bvs_cell.sv]
// One element cell of the store chain.
module bvs_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                                   clk,
    input  bvs_pkg::bvs_cmd_t                      cmd,
    input  logic signed [bvs_pkg::BVS_DATA_W-1:0]  lo_data,
    input  logic signed [bvs_pkg::BVS_DATA_W-1:0]  up_data,
    input  logic signed [bvs_pkg::BVS_DATA_W-1:0]  wrap_data,
    output logic signed [bvs_pkg::BVS_DATA_W-1:0]  data
);
    import bvs_pkg::*;

    localparam logic [BVS_POS_W-1:0] MY_POS = BVS_POS_W'(CELL_IDX);

    logic signed [BVS_DATA_W-1:0] data_reg;
    logic signed [BVS_DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (cmd.kind)
            CMD_WRITE:
            begin
                if (MY_POS == cmd.pos)
                begin
                    data_next = cmd.value;
                end
            end
            CMD_INSERT:
            begin
                if (MY_POS == cmd.pos)
                begin
                    data_next = cmd.value;
                end
                else if ((MY_POS > cmd.pos) && (MY_POS <= cmd.lim))
                begin
                    data_next = lo_data;
                end
            end
            CMD_ROTATE:
            begin
                if (MY_POS < cmd.lim)
                begin
                    data_next = up_data;
                end
                else if (MY_POS == cmd.lim)
                begin
                    data_next = wrap_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[rtl/core/bounded_vector_store.sv]
// Bounded vector store: top level with control sequencer and chain of element cells.
// Each accepted beat gives one registered result beat; for a reverse of n > 1
//   elements that beat comes once the rotation walk is done.
// Throughput: one beat per cycle unless the result stalls, apart from reverse,
//   which holds the input while the cell chain rotates its prefix one step a cycle.
// Reset (rst_n low, asynchronous): count and control clear; cell contents are
//   left as they are and are only read after being written.
module bounded_vector_store #(
    parameter int DEPTH = bvs_pkg::BVS_DEPTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [bvs_pkg::BVS_FUNC_W-1:0]          func,
    input  logic signed [bvs_pkg::BVS_DATA_W-1:0]   value,
    input  logic [bvs_pkg::BVS_IDX_W-1:0]           index,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [bvs_pkg::BVS_DATA_W-1:0]   read_value,
    output logic [bvs_pkg::BVS_STAT_W-1:0]          status,
    output logic [bvs_pkg::BVS_COUNT_W-1:0]         count,
    output logic                                    is_empty
);
    import bvs_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > BVS_IDX_W) ? CNT_W : BVS_IDX_W;
    // Only the first 2**IDX_W cells are reachable by a read index.
    localparam int RD_N  = (DEPTH < (2 ** BVS_IDX_W)) ? DEPTH : (2 ** BVS_IDX_W);

    typedef enum logic {
        S_IDLE,
        S_REV
    } state_t;

    state_t                       state_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [CNT_W-1:0]             lim_reg;    // last position of the prefix still to rotate
    logic                         out_valid_reg;
    logic signed [BVS_DATA_W-1:0] read_value_reg;
    bvs_status_t                  status_reg;
    logic [CNT_W-1:0]             out_count_reg;

    logic                         accept;
    logic                         start_rev;
    logic                         rev_done;
    logic                         is_full;
    logic                         idx_ge;
    bvs_status_t                  res_status;
    logic signed [BVS_DATA_W-1:0] res_rd;
    logic signed [BVS_DATA_W-1:0] rd_mux;
    bvs_cmd_t                     cmd;

    logic signed [BVS_DATA_W-1:0] cell_data [DEPTH];

    // ---------------------------------------------------------------------
    // Handshake: input stalls during a reverse walk or when the result
    // register is full and not being drained this cycle.
    // ---------------------------------------------------------------------
    assign in_stall = (state_reg == S_REV) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign idx_ge   = (CMP_W'(index) >= CMP_W'(count_reg));
    assign rev_done = (state_reg == S_REV) && (lim_reg == CNT_W'(1));

    // Read port over the index-reachable cells.
    always_comb
    begin
        rd_mux = '0;
        for (int i = 0; i < RD_N; i++)
        begin
            if (index == BVS_IDX_W'(i))
            begin
                rd_mux = cell_data[i];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Operation decode: builds the cell command and the result fields.
    // ---------------------------------------------------------------------
    always_comb
    begin
        cmd.kind   = CMD_HOLD;
        cmd.pos    = '0;
        cmd.lim    = BVS_POS_W'(lim_reg);
        cmd.value  = value;
        count_next = count_reg;
        res_status = STAT_OK;
        res_rd     = '0;
        start_rev  = 1'b0;

        if (state_reg == S_REV)
        begin
            // Rotate prefix [0..lim] left by one place.
            cmd.kind = CMD_ROTATE;
        end
        else if (accept)
        begin
            unique case (bvs_func_t'(func))
                FN_APPEND:
                begin
                    if (is_full)
                    begin
                        res_status = STAT_FULL;
                    end
                    else
                    begin
                        cmd.kind   = CMD_WRITE;
                        cmd.pos    = BVS_POS_W'(count_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                FN_POP:
                begin
                    if (count_reg == '0)
                    begin
                        res_status = STAT_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                FN_SET:
                begin
                    if (idx_ge)
                    begin
                        res_status = STAT_RANGE;
                    end
                    else
                    begin
                        cmd.kind = CMD_WRITE;
                        cmd.pos  = BVS_POS_W'(index);
                    end
                end
                FN_INSERT:
                begin
                    // Range check takes precedence over the full check.
                    if (idx_ge)
                    begin
                        res_status = STAT_RANGE;
                    end
                    else if (is_full)
                    begin
                        res_status = STAT_FULL;
                    end
                    else
                    begin
                        cmd.kind   = CMD_INSERT;
                        cmd.pos    = BVS_POS_W'(index);
                        cmd.lim    = BVS_POS_W'(count_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                FN_REVERSE:
                begin
                    start_rev = (count_reg > CNT_W'(1));
                end
                FN_CLEAR:
                begin
                    count_next = '0;
                end
                FN_READ:
                begin
                    if (idx_ge)
                    begin
                        res_status = STAT_RANGE;
                        res_rd     = (count_reg == '0) ? '0 : cell_data[0];
                    end
                    else
                    begin
                        res_rd = rd_mux;
                    end
                end
                default:
                begin
                    res_status = STAT_OK;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer, count and result register.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            lim_reg        <= '0;
            out_valid_reg  <= 1'b0;
            read_value_reg <= '0;
            status_reg     <= STAT_OK;
            out_count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start_rev)
                    begin
                        state_reg <= S_REV;
                        lim_reg   <= count_reg - CNT_W'(1);
                    end
                end
                S_REV:
                begin
                    if (rev_done)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        lim_reg <= lim_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (accept && !start_rev)
            begin
                out_valid_reg  <= 1'b1;
                read_value_reg <= res_rd;
                status_reg     <= res_status;
                out_count_reg  <= count_next;
            end
            else if (rev_done)
            begin
                out_valid_reg  <= 1'b1;
                read_value_reg <= '0;
                status_reg     <= STAT_OK;
                out_count_reg  <= count_reg;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Cell chain: each cell sees its lower and upper neighbor plus cell 0.
    // ---------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [BVS_DATA_W-1:0] lo_d;
        logic signed [BVS_DATA_W-1:0] up_d;

        if (g == 0)
        begin : g_lo_edge
            assign lo_d = '0;
        end
        else
        begin : g_lo_mid
            assign lo_d = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_up_edge
            assign up_d = '0;
        end
        else
        begin : g_up_mid
            assign up_d = cell_data[g+1];
        end

        bvs_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .lo_data   (lo_d),
            .up_data   (up_d),
            .wrap_data (cell_data[0]),
            .data      (cell_data[g])
        );
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign count      = BVS_COUNT_W'(out_count_reg);
    assign is_empty   = (out_count_reg == '0);

endmodule

[rtl/core/bvs_checker.sv]
// Port-level checks for the bounded vector store, bound to the top level.
module bvs_checker #(
    parameter int DEPTH = bvs_pkg::BVS_DEPTH_DEF
) (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    in_stall,
    input logic                                    out_valid,
    input logic                                    out_stall,
    input logic signed [bvs_pkg::BVS_DATA_W-1:0]   read_value,
    input logic [bvs_pkg::BVS_STAT_W-1:0]          status,
    input logic [bvs_pkg::BVS_COUNT_W-1:0]         count,
    input logic                                    is_empty
);
    import bvs_pkg::*;

    localparam logic [BVS_COUNT_W-1:0] FULL_COUNT = BVS_COUNT_W'(DEPTH);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(status)
            && $stable(count) && $stable(is_empty))
        else $error("result beat changed while stalled");

    // A stalled result beat blocks the input.
    a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input open while result stalled");

    // Empty flag tracks the reported count.
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (count == '0)))
        else $error("is_empty disagrees with count");

    // Empty status only on an empty store.
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_EMPTY) |-> is_empty)
        else $error("empty status with elements held");

    // Full status only on a full store.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_FULL) |-> (count == FULL_COUNT))
        else $error("full status below capacity");

endmodule

bind bounded_vector_store bvs_checker #(.DEPTH(DEPTH)) u_bvs_checker (.*);

[bench/tb_bounded_vector_store.sv]
// Testbench for bounded_vector_store: random and directed beats checked against a shadow store.
module tb_bounded_vector_store;
    import bvs_pkg::*;

    localparam int DEPTH_TB     = BVS_DEPTH_DEF;
    localparam int RANDOM_BEATS = 1750;
    // Code 7 has no operation behind it; the block must leave the store alone.
    localparam logic [BVS_FUNC_W-1:0] FN_UNUSED = 3'd7;

    // Random traffic runs in phases, most leaning the mix of operations one way so
    // the fill level sweeps from empty to full and back instead of hovering low.
    typedef enum {PH_GROW, PH_DRAIN, PH_CHURN, PH_NOISE} phase_t;

    typedef struct {
        logic signed [BVS_DATA_W-1:0] rd;
        bvs_status_t                  st;
        logic [BVS_COUNT_W-1:0]       cnt;
        logic                         empty;
    } vec_result_t;

    // Shadow copy of the element store plus the queue of results still owed.
    class store_tracker;
        logic signed [BVS_DATA_W-1:0] shadow [DEPTH_TB];
        int unsigned                  fill;
        vec_result_t                  expected_results [$];
        int                           errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        // Apply one accepted beat to the shadow store and queue its result.
        function void note_beat(logic [BVS_FUNC_W-1:0] fn, logic signed [BVS_DATA_W-1:0] val,
                                logic [BVS_IDX_W-1:0] idx);
            vec_result_t                  r;
            int unsigned                  k;
            int unsigned                  lo;
            int unsigned                  hi;
            logic signed [BVS_DATA_W-1:0] t;
            r.rd = '0;
            r.st = STAT_OK;
            case (fn)
                FN_APPEND:
                    if (fill >= DEPTH_TB)
                        r.st = STAT_FULL;
                    else
                    begin
                        shadow[fill] = val;
                        fill++;
                    end
                FN_POP:
                    if (fill == 0)
                        r.st = STAT_EMPTY;
                    else
                        fill--;
                FN_SET:
                    if (idx >= fill)
                        r.st = STAT_RANGE;
                    else
                        shadow[idx] = val;
                FN_INSERT:
                    // range check wins over the full check
                    if (idx >= fill)
                        r.st = STAT_RANGE;
                    else if (fill >= DEPTH_TB)
                        r.st = STAT_FULL;
                    else
                    begin
                        for (k = fill; k > idx; k--)
                            shadow[k] = shadow[k - 1];
                        shadow[idx] = val;
                        fill++;
                    end
                FN_REVERSE:
                    if (fill > 1)
                    begin
                        lo = 0;
                        hi = fill - 1;
                        while (lo < hi)
                        begin
                            t          = shadow[lo];
                            shadow[lo] = shadow[hi];
                            shadow[hi] = t;
                            lo++;
                            hi--;
                        end
                    end
                FN_CLEAR:
                    fill = 0;
                FN_READ:
                    if (idx >= fill)
                    begin
                        r.st = STAT_RANGE;
                        r.rd = (fill > 0) ? shadow[0] : '0;
                    end
                    else
                        r.rd = shadow[idx];
                default:
                    ;
            endcase
            r.cnt   = BVS_COUNT_W'(fill);
            r.empty = (fill == 0);
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void flag(string field, logic [BVS_DATA_W-1:0] want, logic [BVS_DATA_W-1:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        endfunction

        // Compare one accepted result beat with the oldest queued expectation.
        function void check_result(logic signed [BVS_DATA_W-1:0] rd, logic [BVS_STAT_W-1:0] st,
                                   logic [BVS_COUNT_W-1:0] cnt, logic empty);
            vec_result_t want;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing pending, expected none, %s %h/%h/%h/%h",
                         $time, "actual", rd, st, cnt, empty);
                return;
            end
            want = expected_results.pop_front();
            if (rd !== want.rd)
                flag("read_value", want.rd, rd);
            if (st !== want.st)
                flag("status", BVS_DATA_W'(want.st), BVS_DATA_W'(st));
            if (cnt !== want.cnt)
                flag("count", BVS_DATA_W'(want.cnt), BVS_DATA_W'(cnt));
            if (empty !== want.empty)
                flag("is_empty", BVS_DATA_W'(want.empty), BVS_DATA_W'(empty));
        endfunction

        function void check_drained();
            if (expected_results.size() != 0)
            begin
                errors++;
                $display("%0t: results missing at end, expected %0d more, actual 0",
                         $time, expected_results.size());
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [BVS_FUNC_W-1:0]         func;
    logic signed [BVS_DATA_W-1:0]  value;
    logic [BVS_IDX_W-1:0]          index;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [BVS_DATA_W-1:0]  read_value;
    logic [BVS_STAT_W-1:0]         status;
    logic [BVS_COUNT_W-1:0]        count;
    logic                          is_empty;

    store_tracker tracker;

    bounded_vector_store #(
        .DEPTH(DEPTH_TB)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .value      (value),
        .index      (index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .status     (status),
        .count      (count),
        .is_empty   (is_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop. Worst case per beat is the longest send gap, a full-depth reverse
    // and the longest result stall; this allows several times that.
    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 50);
    endfunction

    // Data values lean on the sign boundaries now and then; otherwise any 32-bit pattern.
    function automatic logic signed [BVS_DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [BVS_FUNC_W-1:0] pick_func(phase_t mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            PH_GROW:
                if (r < 50)      return FN_APPEND;
                else if (r < 72) return FN_INSERT;
                else if (r < 80) return FN_READ;
                else if (r < 88) return FN_SET;
                else if (r < 94) return FN_REVERSE;
                else             return FN_POP;
            PH_DRAIN:
                if (r < 55)      return FN_POP;
                else if (r < 70) return FN_READ;
                else if (r < 80) return FN_SET;
                else if (r < 87) return FN_REVERSE;
                else if (r < 92) return FN_INSERT;
                else if (r < 97) return FN_APPEND;
                else             return FN_CLEAR;
            PH_CHURN:
                if (r < 20)      return FN_APPEND;
                else if (r < 38) return FN_POP;
                else if (r < 53) return FN_SET;
                else if (r < 65) return FN_INSERT;
                else if (r < 85) return FN_READ;
                else if (r < 97) return FN_REVERSE;
                else if (r < 99) return FN_CLEAR;
                else             return FN_UNUSED;
            default:
                return BVS_FUNC_W'($urandom_range(0, 7));
        endcase
    endfunction

    // Mostly a live position so set/insert/read do real work; some anywhere for range errors.
    function automatic logic [BVS_IDX_W-1:0] pick_index(phase_t mode);
        if (mode == PH_NOISE || tracker.fill == 0 || $urandom_range(0, 99) < 15)
            return BVS_IDX_W'($urandom_range(0, 15));
        else
            return BVS_IDX_W'($urandom_range(0, tracker.fill - 1));
    endfunction

    // Entered and left at a falling edge. Valid stays high between back-to-back
    // beats; the shadow store is updated at the edge where the beat is taken.
    task automatic push_beat(input logic [BVS_FUNC_W-1:0] fn, input logic signed [BVS_DATA_W-1:0] val,
                             input logic [BVS_IDX_W-1:0] idx, input bit quiet);
        int gap;
        gap = quiet ? 0 : pick_idle();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= fn;
        value    <= val;
        index    <= idx;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_beat(fn, val, idx);
        @(negedge clk);
    endtask

    // Result side: free-running stretches broken by stalls of random length.
    initial
    begin
        int free_run;
        int hold;
        int r;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                free_run = $urandom_range(1, 6);
            else if (r < 90)
                free_run = $urandom_range(7, 30);
            else
                free_run = $urandom_range(40, 150);
            out_stall <= 1'b0;
            repeat (free_run) @(negedge clk);
            hold = pick_idle();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
        end
    end

    // Outputs are taken at the rising edge, before the block's own updates land.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(read_value, status, count, is_empty);
    end

    initial
    begin
        phase_t mode;
        bit     quiet;
        int     span;
        int     sent;
        int     waited;
        logic [BVS_FUNC_W-1:0] fn;

        tracker  = new();
        rst_n    = 1'b0;
        in_valid = 1'b0;
        func     = FN_APPEND;
        value    = '0;
        index    = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: every operation on an empty store first, then a small prefix
        // built from the sign extremes and worked over by insert/set/reverse/read.
        push_beat(FN_READ,    32'h1111_1111, 4'd15, 1'b0);  // read empty: zero, range
        push_beat(FN_POP,     32'h0,         4'd0,  1'b0);  // pop empty
        push_beat(FN_REVERSE, 32'h0,         4'd0,  1'b0);  // reverse empty: no-op
        push_beat(FN_CLEAR,   32'h0,         4'd0,  1'b0);  // clear empty: no-op
        push_beat(FN_INSERT,  32'h2222_2222, 4'd0,  1'b0);  // insert empty: range
        push_beat(FN_SET,     32'h3333_3333, 4'd0,  1'b0);  // set empty: range
        push_beat(FN_UNUSED,  32'hFFFF_FFFF, 4'd15, 1'b0);  // unused code
        push_beat(FN_APPEND,  32'h7FFF_FFFF, 4'd0,  1'b0);
        push_beat(FN_REVERSE, 32'h0,         4'd0,  1'b0);  // single element
        push_beat(FN_APPEND,  32'h8000_0000, 4'd0,  1'b0);
        push_beat(FN_APPEND,  32'hFFFF_FFFF, 4'd0,  1'b0);
        push_beat(FN_APPEND,  32'h0000_0000, 4'd0,  1'b0);
        push_beat(FN_INSERT,  32'h5A5A_5A5A, 4'd0,  1'b0);  // insert at the bottom
        push_beat(FN_INSERT,  32'hA5A5_A5A5, 4'd4,  1'b0);  // insert at the top slot
        push_beat(FN_INSERT,  32'h4444_4444, 4'd6,  1'b0);  // index == count: range
        push_beat(FN_SET,     32'h1234_5678, 4'd5,  1'b0);
        push_beat(FN_SET,     32'h5555_5555, 4'd15, 1'b0);  // set past count: range
        push_beat(FN_REVERSE, 32'h0,         4'd0,  1'b0);  // even length
        push_beat(FN_READ,    32'h0,         4'd0,  1'b0);
        push_beat(FN_READ,    32'h0,         4'd5,  1'b0);
        push_beat(FN_READ,    32'h0,         4'd15, 1'b0);  // past count: element 0
        push_beat(FN_POP,     32'h0,         4'd0,  1'b0);
        push_beat(FN_REVERSE, 32'h0,         4'd0,  1'b0);  // odd length
        push_beat(FN_CLEAR,   32'h0,         4'd0,  1'b0);
        push_beat(FN_READ,    32'h0,         4'd0,  1'b0);  // after clear: zero, range

        // Random phases. A quarter of them send back to back with no gaps; the
        // full-store cases come from grow phases, which outrun pops and clears.
        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            mode  = phase_t'($urandom_range(0, 3));
            quiet = ($urandom_range(0, 3) == 0);
            span  = $urandom_range(20, 80);
            repeat (span)
            begin
                fn = pick_func(mode);
                push_beat(fn, pick_value(), pick_index(mode), quiet);
                sent++;
            end
        end
        in_valid <= 1'b0;

        // Drain, then wait on to catch any stray result beats.
        waited = 0;
        while (tracker.expected_results.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        tracker.check_drained();

        if (tracker.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
